@@ hdl/cfp_pkg.sv @@
`timescale 1ns / 1ps

package cfp_pkg;

  // frame layout
  localparam int HDR_LEN          = 8;
  localparam int MAX_PAYLOAD_DFLT = 255;

  // crc-8, poly x^8 + x^2 + x + 1, msb first
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // register reset values
  localparam logic [7:0] SYNC_RST    = 8'd60;
  localparam logic [7:0] MASK_RST    = 8'd248;
  localparam logic [7:0] VERSION_RST = 8'd32;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC    = 2'd0,
    CFG_MASK    = 2'd1,
    CFG_VERSION = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] type_mask;
    logic [7:0] type_version;
  } cfg_t;

  typedef enum logic [2:0] {
    EV_HDR  = 3'd0,
    EV_DATA = 3'd1,
    EV_GOOD = 3'd2,
    EV_BAD  = 3'd3,
    EV_DROP = 3'd4
  } event_t;

  typedef enum logic [5:0] {
    PH_SYNC = 6'b000001,
    PH_TYPE = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_ID   = 6'b001000,
    PH_DATA = 6'b010000,
    PH_CRC  = 6'b100000
  } phase_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

@@ hdl/cfp_cfg_regs.sv @@
`timescale 1ns / 1ps

module cfp_cfg_regs import cfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value   <= SYNC_RST;
      cfg.type_mask    <= MASK_RST;
      cfg.type_version <= VERSION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC:    cfg.sync_value   <= cfg_data;
        CFG_MASK:    cfg.type_mask    <= cfg_data;
        CFG_VERSION: cfg.type_version <= cfg_data;
        default:     ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

@@ hdl/cfp_parser.sv @@
`timescale 1ns / 1ps

module cfp_parser import cfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DFLT
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [7:0]  byte_index,
  output logic [7:0]  msg_type,
  output logic [31:0] obj_id,
  output logic [8:0]  frame_length
);

  localparam logic [15:0] LEN_MIN = 16'(HDR_LEN);
  localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD + HDR_LEN);

  phase_t      phase, phase_next;
  logic [7:0]  crc, crc_next;
  logic [7:0]  count, count_next;
  logic [7:0]  type_store, type_next;
  logic [8:0]  len_store, len_next;
  logic [31:0] id_store, id_next;
  event_t      ev;
  logic [7:0]  dbyte, didx;
  logic [7:0]  crc_upd;
  logic [15:0] full_len;
  logic        accept;

  // result register frees up when its item is taken
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign crc_upd  = crc8_update(crc, rx_byte);
  assign full_len = {rx_byte, len_store[7:0]};

  always_comb begin
    phase_next = phase;
    crc_next   = crc;
    count_next = count;
    type_next  = type_store;
    len_next   = len_store;
    id_next    = id_store;
    ev         = EV_HDR;
    dbyte      = 8'd0;
    didx       = 8'd0;
    case (phase)
      PH_TYPE: begin
        crc_next = crc_upd;
        if ((rx_byte & cfg.type_mask) == cfg.type_version) begin
          type_next  = rx_byte;
          count_next = 8'd0;
          phase_next = PH_LEN;
        end else begin
          ev         = EV_DROP;
          phase_next = PH_SYNC;
        end
      end
      PH_LEN: begin
        crc_next = crc_upd;
        if (count == 8'd0) begin
          len_next   = {1'b0, rx_byte};
          count_next = 8'd1;
        end else begin
          if (full_len < LEN_MIN || full_len > LEN_MAX) begin
            ev         = EV_DROP;
            phase_next = PH_SYNC;
          end else begin
            len_next   = full_len[8:0];
            phase_next = PH_ID;
          end
          count_next = 8'd0;
        end
      end
      PH_ID: begin
        crc_next = crc_upd;
        // little endian, first byte clears the upper lanes
        case (count[1:0])
          2'd0:    id_next = {24'd0, rx_byte};
          2'd1:    id_next[15:8]  = rx_byte;
          2'd2:    id_next[23:16] = rx_byte;
          default: id_next[31:24] = rx_byte;
        endcase
        if (count >= 8'd3) begin
          count_next = 8'd0;
          phase_next = (len_store == 9'(HDR_LEN)) ? PH_CRC : PH_DATA;
        end else begin
          count_next = count + 8'd1;
        end
      end
      PH_DATA: begin
        crc_next = crc_upd;
        ev       = EV_DATA;
        dbyte    = rx_byte;
        didx     = count;
        if ({1'b0, count} + 9'd1 >= len_store - 9'(HDR_LEN)) begin
          count_next = 8'd0;
          phase_next = PH_CRC;
        end else begin
          count_next = count + 8'd1;
        end
      end
      PH_CRC: begin
        ev         = (rx_byte == crc) ? EV_GOOD : EV_BAD;
        phase_next = PH_SYNC;
      end
      default: begin
        // hunting for sync
        phase_next = PH_SYNC;
        if (rx_byte == cfg.sync_value) begin
          crc_next   = crc8_update(CRC_INIT, rx_byte);
          phase_next = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC;
      crc        <= CRC_INIT;
      count      <= 8'd0;
      type_store <= 8'd0;
      len_store  <= 9'd0;
      id_store   <= 32'd0;
    end else if (accept) begin
      phase      <= phase_next;
      crc        <= crc_next;
      count      <= count_next;
      type_store <= type_next;
      len_store  <= len_next;
      id_store   <= id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_res    <= ev;
      data_byte    <= dbyte;
      byte_index   <= didx;
      msg_type     <= type_next;
      obj_id       <= id_next;
      frame_length <= len_next;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(event_res) && $stable(obj_id))
    else $error("stalled result changed");

  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_DATA) |-> (frame_length > 9'(HDR_LEN)
      && {1'b0, byte_index} < frame_length - 9'(HDR_LEN)))
    else $error("payload byte outside declared length");

  a_side_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_DATA) |-> (data_byte == 8'd0 && byte_index == 8'd0))
    else $error("data fields set on non-payload result");

endmodule

@@ hdl/crc8_checked_frame_parser.sv @@
`timescale 1ns / 1ps
// a result is registered when its byte is accepted and appears in the next cycle
// throughput: one byte per cycle; the single result register is the only buffer,
//   so input stall follows output stall while a result is held
// reset (rst, synchronous): parser back to sync hunt, crc and stored header fields
//   cleared, result register empty, registers to sync 60, mask 248, version 32

module crc8_checked_frame_parser import cfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DFLT  // largest payload in bytes, 1 to 255
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // received byte stream, one item per byte
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  // one result item per received byte
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           event_res,
  output logic [7:0]           data_byte,
  output logic [7:0]           byte_index,
  output logic [7:0]           msg_type,
  output logic [31:0]          obj_id,
  output logic [8:0]           frame_length
);

  // live register values for the parser
  cfg_t cfg;

  cfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // frame state machine, running crc and result register; each byte
  // is handled in the cycle it is accepted
  cfp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .msg_type     (msg_type),
    .obj_id       (obj_id),
    .frame_length (frame_length)
  );

endmodule

@@ tb/frame_result_checker.sv @@
`timescale 1ns / 1ps

module frame_result_checker import cfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DFLT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           rx_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [2:0]           event_res,
  input  logic [7:0]           data_byte,
  input  logic [7:0]           byte_index,
  input  logic [7:0]           msg_type,
  input  logic [31:0]          obj_id,
  input  logic [8:0]           frame_length,
  output int                   mismatches,
  output int                   results_pending
);

  typedef struct {
    event_t      ev;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [7:0]  mtype;
    logic [31:0] id;
    logic [8:0]  flen;
  } frame_result_t;

  frame_result_t expected_results[$];
  int            fail_total = 0;

  // parser copy
  cfg_t        regs;
  phase_t      ph;
  logic [7:0]  run_crc;
  logic [7:0]  count;
  logic [7:0]  type_store;
  logic [8:0]  len_store;
  logic [31:0] id_store;

  // bit-serial crc-8, data msb first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  task automatic clear_parser();
    regs       = '{sync_value: SYNC_RST, type_mask: MASK_RST, type_version: VERSION_RST};
    ph         = PH_SYNC;
    run_crc    = CRC_INIT;
    count      = '0;
    type_store = '0;
    len_store  = '0;
    id_store   = '0;
  endtask

  task automatic advance_parser(input logic [7:0] c, output frame_result_t r);
    logic [15:0] full_len;
    r.ev    = EV_HDR;
    r.data  = '0;
    r.index = '0;
    case (ph)
      PH_TYPE: begin
        run_crc = crc_step(run_crc, c);
        if ((c & regs.type_mask) == regs.type_version) begin
          type_store = c;
          count      = '0;
          ph         = PH_LEN;
        end else begin
          r.ev = EV_DROP;
          ph   = PH_SYNC;
        end
      end
      PH_LEN: begin
        run_crc = crc_step(run_crc, c);
        if (count == 0) begin
          len_store = {1'b0, c};
          count     = 8'd1;
        end else begin
          full_len = {c, len_store[7:0]};
          if (int'(full_len) < HDR_LEN || int'(full_len) > MAX_PAYLOAD + HDR_LEN) begin
            r.ev = EV_DROP;
            ph   = PH_SYNC;
          end else begin
            len_store = full_len[8:0];
            ph        = PH_ID;
          end
          count = '0;
        end
      end
      PH_ID: begin
        run_crc = crc_step(run_crc, c);
        if (count == 0) id_store = {24'h0, c};
        else id_store = id_store | ({24'h0, c} << (8 * count[1:0]));
        if (count >= 3) begin
          count = '0;
          ph    = (int'(len_store) == HDR_LEN) ? PH_CRC : PH_DATA;
        end else begin
          count = count + 8'd1;
        end
      end
      PH_DATA: begin
        run_crc = crc_step(run_crc, c);
        r.ev    = EV_DATA;
        r.data  = c;
        r.index = count;
        if (int'(count) + 1 >= int'(len_store) - HDR_LEN) begin
          count = '0;
          ph    = PH_CRC;
        end else begin
          count = count + 8'd1;
        end
      end
      PH_CRC: begin
        r.ev = (c == run_crc) ? EV_GOOD : EV_BAD;
        ph   = PH_SYNC;
      end
      default: begin
        ph = PH_SYNC;
        if (c == regs.sync_value) begin
          run_crc = crc_step(CRC_INIT, c);
          ph      = PH_TYPE;
        end
      end
    endcase
    r.mtype = type_store;
    r.id    = id_store;
    r.flen  = len_store;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_total++;
      if (fail_total <= 10)
        $display("mismatch %s: expected 0x%0h actual 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t next_res;
    if (rst) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("unexpected result item: event %0d data 0x%0h", event_res, data_byte);
        end else begin
          want = expected_results.pop_front();
          check_field("event_res", 32'(want.ev), 32'(event_res));
          check_field("data_byte", 32'(want.data), 32'(data_byte));
          check_field("byte_index", 32'(want.index), 32'(byte_index));
          check_field("msg_type", 32'(want.mtype), 32'(msg_type));
          check_field("obj_id", want.id, obj_id);
          check_field("frame_length", 32'(want.flen), 32'(frame_length));
        end
      end
      // an item accepted on the same edge as a write still sees the old registers
      if (in_valid && !in_stall) begin
        advance_parser(rx_byte, next_res);
        expected_results.push_back(next_res);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC:    regs.sync_value   = cfg_data;
          CFG_MASK:    regs.type_mask    = cfg_data;
          CFG_VERSION: regs.type_version = cfg_data;
          default: ;
        endcase
      end
    end
    mismatches      <= fail_total;
    results_pending <= expected_results.size();
  end

endmodule

@@ tb/tb_crc8_checked_frame_parser.sv @@
`timescale 1ns / 1ps

module tb_crc8_checked_frame_parser;
  import cfp_pkg::*;

  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // random items per configuration phase
  localparam int PHASE_ITEMS = 40;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic [7:0]           rx_byte   = '0;
  logic                 out_stall = 1'b0;

  logic        cfg_ready;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [7:0]  msg_type;
  logic [31:0] obj_id;
  logic [8:0]  frame_length;

  int mismatches;
  int results_pending;

  // idle percentages for sender gaps and receiver stalls
  int gap_pct      = 0;
  int stall_pct    = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;

  // stimulus-side copy of the registers, used to build frames
  logic [7:0] sync_cur = SYNC_RST;
  logic [7:0] mask_cur = MASK_RST;
  logic [7:0] ver_cur  = VERSION_RST;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  crc8_checked_frame_parser dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .msg_type     (msg_type),
    .obj_id       (obj_id),
    .frame_length (frame_length)
  );

  frame_result_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_res       (event_res),
    .data_byte       (data_byte),
    .byte_index      (byte_index),
    .msg_type        (msg_type),
    .obj_id          (obj_id),
    .frame_length    (frame_length),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  // receiver side: random stall, never during reset
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // hang detection: any accepted handshake restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
  task automatic set_idling(input int mode);
    case (mode)
      1: begin gap_pct = 49; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 49; end
      3: begin gap_pct = 29; stall_pct = 29; end
      default: begin gap_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // one item; valid stays high on return so the next item follows back to back
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // drop valid and wait until every expected result has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    // margin after the last registered result
    repeat (4) @(posedge clk);
  endtask

  // valid is held across back-to-back writes and dropped by the caller
  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input int p);
    logic [7:0] s;
    logic [7:0] m;
    logic [7:0] v;
    case (p)
      1: begin s = SYNC_RST; m = MASK_RST; v = VERSION_RST; end
      // all-ones mask: exact type compare
      2: begin s = 8'h00; m = 8'hFF; v = 8'hFF; end
      // empty mask: every type passes
      3: begin s = 8'hFF; m = 8'h00; v = 8'h00; end
      5: begin s = 8'hA5; m = 8'hF0; v = 8'h50; end
      // fully random, version may be unreachable so frames mostly drop
      6: begin s = 8'($urandom); m = 8'($urandom); v = 8'($urandom); end
      7: begin s = 8'h80; m = 8'h0F; v = 8'h0A; end
      8: begin s = SYNC_RST; m = 8'hFC; v = 8'h20; end
      default: begin
        s = 8'($urandom);
        m = 8'($urandom);
        v = 8'($urandom) & m;
      end
    endcase
    write_reg(CFG_SYNC, s);
    write_reg(CFG_MASK, m);
    write_reg(CFG_VERSION, v);
    cfg_valid <= 1'b0;
    sync_cur = s;
    mask_cur = m;
    ver_cur  = v;
  endtask

  // a type byte that passes the version check, where one exists
  function automatic logic [7:0] good_type();
    return ver_cur | (8'($urandom) & ~mask_cur);
  endfunction

  function automatic logic [7:0] bad_type();
    logic [7:0] t;
    t = 8'($urandom);
    for (int k = 0; k < 16 && (t & mask_cur) == ver_cur; k++) t = 8'($urandom);
    return t;
  endfunction

  // header always goes out; the rest only if the parser will keep the frame
  task automatic send_frame(input logic [7:0] typ, input logic [15:0] len,
                            input logic [31:0] id, input bit bad_crc);
    logic [7:0] frame_bytes[$];
    logic [7:0] crc;
    bit         kept;
    kept = ((typ & mask_cur) == ver_cur) && int'(len) >= HDR_LEN
           && int'(len) <= MAX_PAYLOAD_DFLT + HDR_LEN;
    frame_bytes = '{sync_cur, typ, len[7:0], len[15:8]};
    if (kept) begin
      for (int k = 0; k < 4; k++) frame_bytes.push_back(id[8*k +: 8]);
      repeat (int'(len) - HDR_LEN) frame_bytes.push_back(8'($urandom));
      crc = CRC_INIT;
      foreach (frame_bytes[k]) crc = crc8_update(crc, frame_bytes[k]);
      frame_bytes.push_back(bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
    end
    foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
  endtask

  // out-of-range lengths around both limits and in the high byte
  function automatic logic [15:0] bad_length();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'(HDR_LEN - 1);
      2: return 16'(MAX_PAYLOAD_DFLT + HDR_LEN + 1);
      3: return 16'hFFFF;
      default: return 16'($urandom_range(MAX_PAYLOAD_DFLT + HDR_LEN + 1, 65535));
    endcase
  endfunction

  initial begin
    int phase_start;
    int pick;
    int npay;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    set_idling(0);
    send_byte(8'h00);
    // shortest frame: no payload, crc right after the object id
    send_frame(8'h27, 16'(HDR_LEN), 32'hFFFF_FFFF, 1'b0);
    // one payload byte, corrupted crc
    send_frame(8'h20, 16'(HDR_LEN + 1), 32'h0000_0000, 1'b1);
    // type mismatch on a byte equal to sync: consumed, not a new frame start
    send_byte(SYNC_RST);
    send_byte(SYNC_RST);
    // all-ones length is dropped
    send_frame(8'h20, 16'hFFFF, 32'h0, 1'b0);

    // random part, one register setting and idle pattern per phase
    for (int p = 1; p <= 8; p++) begin
      settle();
      apply_setting(p);
      set_idling(p % 4);
      phase_start = items_sent;
      // largest legal length, once
      if (p == 5) send_frame(good_type(), 16'(MAX_PAYLOAD_DFLT + HDR_LEN), $urandom, 1'b0);
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // well-formed frame, sometimes with a bad crc, mostly short payloads
          if ($urandom_range(0, 49) == 0) npay = $urandom_range(100, MAX_PAYLOAD_DFLT);
          else npay = $urandom_range(0, 12);
          send_frame(good_type(), 16'(npay + HDR_LEN), $urandom, $urandom_range(0, 4) == 0);
        end else if (pick < 85) begin
          // broken header: wrong type or bad length
          if ($urandom_range(0, 1) == 0)
            send_frame(bad_type(), 16'(HDR_LEN + 2), $urandom, 1'b0);
          else
            send_frame(good_type(), bad_length(), $urandom, 1'b0);
        end else begin
          // line noise, sync value sprinkled in
          repeat ($urandom_range(1, 6))
            send_byte(($urandom_range(0, 3) == 0) ? sync_cur : 8'($urandom));
        end
      end
    end

    settle();
    if (mismatches == 0 && results_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ crc8_checked_frame_parser.f @@
hdl/cfp_pkg.sv
hdl/cfp_cfg_regs.sv
hdl/cfp_parser.sv
hdl/crc8_checked_frame_parser.sv
tb/frame_result_checker.sv
tb/tb_crc8_checked_frame_parser.sv
